@@ rtl/core/ring_fifo_with_id_search_unit_defines.svh @@
// Assertion macros for the ring FIFO with id search RTL.
// Used by rfs_ctrl, which checks its own control logic; no other dependencies.
`ifndef RING_FIFO_WITH_ID_SEARCH_UNIT_DEFINES_SVH
`define RING_FIFO_WITH_ID_SEARCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define RFS_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("rfs assertion failed");

`define RFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfs assertion failed");

`else

`define RFS_ASSERT(label, expr)

`define RFS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/rfs_pkg.sv @@
// Package for the ring FIFO with id search: sizes, codes, word types, ring step.
// No dependencies; imported by the controller and the top level.
package rfs_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    localparam int ID_W    = 16;
    localparam int FIELD_W = 32;
    localparam int COUNT_W = 7;
    localparam int KEEP_W  = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
    localparam int ENTRY_W = ID_W + KEEP_W;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_PEEK   = 2'd2,
        KIND_SEARCH = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCAN
    } state_t;

    typedef struct packed {
        kind_t               kind;
        logic [ID_W-1:0]     passenger_id;
        logic [FIELD_W-1:0]  entry_data;
    } cmd_t;

    typedef struct packed {
        status_t             status;
        logic [ID_W-1:0]     out_id;
        logic [FIELD_W-1:0]  out_data;
        logic                found;
        logic                is_empty;
        logic                is_full;
        logic [COUNT_W-1:0]  fill_count;
    } rsp_t;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos);
        return (pos == IDX_W'(DEPTH - 1)) ? '0 : pos + 1'b1;
    endfunction

endpackage

@@ rtl/core/ring_fifo_with_id_search_unit.sv @@
// Top level of the ring FIFO with id search: sequencer, entry RAM, result register.
// Depends on rfs_pkg, rfs_ram and rfs_ctrl.
//
//  channel   handshake            payload
//  command   start, busy          cmd    (rfs_pkg::cmd_t)
//  result    done (1-cycle pulse) result (rfs_pkg::rsp_t)
//
// A command is taken when start is high and busy is low; busy then stays high until
// the command finishes. Push, and pop/peek/search on an empty queue: done is
// registered from the execute state. Pop and peek: one RAM read of the head entry.
// Search: k entries compared (up to fill count), one RAM read and one id compare
// per entry through the single read port. Reset empties the queue.
// The receiver cannot stall: done is high for one cycle only; result holds until the next result.
module ring_fifo_with_id_search_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rfs_pkg::cmd_t cmd,
    output logic          done,
    output rfs_pkg::rsp_t result
);
    import rfs_pkg::*;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               emit;
    rsp_t               rsp;

    logic               done_reg;
    rsp_t               result_reg;

    rfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .emit      (emit),
        .rsp       (rsp)
    );

    rfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= rsp;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/core/rfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/rfs_ctrl.sv @@
// Sequencer for the ring FIFO: pointers, fill count, RAM control, id compare unit.
// Depends on rfs_pkg and the assertion macros header.
`include "ring_fifo_with_id_search_unit_defines.svh"

module rfs_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  rfs_pkg::cmd_t             cmd,
    output logic                      busy,
    output logic                      ram_we,
    output logic [rfs_pkg::IDX_W-1:0] ram_waddr,
    output logic [rfs_pkg::ENTRY_W-1:0] ram_wdata,
    output logic                      ram_re,
    output logic [rfs_pkg::IDX_W-1:0] ram_raddr,
    input  logic [rfs_pkg::ENTRY_W-1:0] ram_rdata,
    output logic                      emit,
    output rfs_pkg::rsp_t             rsp
);
    import rfs_pkg::*;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [CNT_W-1:0]  left_reg, left_next;

    logic              is_empty_now;
    logic              is_full_now;
    logic              hit;
    logic [ID_W-1:0]   rd_id;
    logic [KEEP_W-1:0] rd_data;
    status_t           status;
    logic [ID_W-1:0]   out_id;
    logic [KEEP_W-1:0] out_data;
    logic              found;

    assign is_empty_now = (occ_reg == '0);
    assign is_full_now  = (occ_reg == CNT_W'(DEPTH));
    assign rd_id        = ram_rdata[KEEP_W +: ID_W];
    assign rd_data      = ram_rdata[KEEP_W-1:0];
    assign hit          = (rd_id == cmd_reg.passenger_id);
    assign busy         = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pos_reg  <= pos_next;
        left_reg <= left_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg.kind)
                    KIND_POP, KIND_PEEK: state_next = is_empty_now ? S_IDLE : S_READ;
                    KIND_SEARCH:         state_next = is_empty_now ? S_IDLE : S_SCAN;
                    default:             state_next = S_IDLE;
                endcase
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (hit || (left_reg == CNT_W'(1)))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next  = cmd_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        pos_next  = pos_reg;
        left_next = left_reg;
        ram_we    = 1'b0;
        ram_waddr = tail_reg;
        ram_wdata = {cmd_reg.passenger_id, cmd_reg.entry_data[KEEP_W-1:0]};
        ram_re    = 1'b0;
        ram_raddr = head_reg;
        emit      = 1'b0;
        status    = STATUS_OK;
        out_id    = '0;
        out_data  = '0;
        found     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg.kind)
                    KIND_PUSH:
                    begin
                        emit = 1'b1;
                        if (is_full_now)
                        begin
                            status = STATUS_FULL;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            tail_next = ring_next(tail_reg);
                            occ_next  = occ_reg + 1'b1;
                        end
                    end
                    KIND_POP, KIND_PEEK:
                    begin
                        if (is_empty_now)
                        begin
                            emit   = 1'b1;
                            status = STATUS_EMPTY;
                        end
                        else
                        begin
                            ram_re = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (is_empty_now)
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            ram_re    = 1'b1;
                            pos_next  = ring_next(head_reg);
                            left_next = occ_reg;
                        end
                    end
                endcase
            end
            S_READ:
            begin
                emit     = 1'b1;
                out_id   = rd_id;
                out_data = rd_data;
                if (cmd_reg.kind == KIND_POP)
                begin
                    head_next = ring_next(head_reg);
                    occ_next  = occ_reg - 1'b1;
                end
            end
            S_SCAN:
            begin
                if (hit || (left_reg == CNT_W'(1)))
                begin
                    emit  = 1'b1;
                    found = hit;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = pos_reg;
                    pos_next  = ring_next(pos_reg);
                    left_next = left_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp.status     = status;
        rsp.out_id     = out_id;
        rsp.out_data   = FIELD_W'(out_data);
        rsp.found      = found;
        rsp.is_empty   = (occ_next == '0);
        rsp.is_full    = (occ_next == CNT_W'(DEPTH));
        rsp.fill_count = COUNT_W'(occ_next);
    end

    `RFS_ASSERT(a_occ_bound, occ_reg <= CNT_W'(DEPTH))
    `RFS_ASSERT(a_emit_busy, !emit || (state_reg != S_IDLE))
    `RFS_ASSERT(a_no_rw_idle, (state_reg != S_IDLE) || (!ram_we && !ram_re))
    `RFS_ASSERT_NEXT(a_accept_exec, start && !busy, state_reg == S_EXEC)
    `RFS_ASSERT_NEXT(a_idle_hold, state_reg == S_IDLE, $stable(occ_reg) && $stable(head_reg))

endmodule

@@ verif/ring_fifo_with_id_search_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ring_fifo_with_id_search_unit: directed and random
// push, pop, peek and search words are checked against a behavioral ring FIFO.
// Depends on rfs_pkg and the unit's RTL.
module ring_fifo_with_id_search_unit_tb;
    import rfs_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = DEPTH + 16;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    cmd_t cmd = '0;
    logic done;
    rsp_t result;

    ring_fifo_with_id_search_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    logic [ID_W-1:0]   shadow_ids  [DEPTH];
    logic [KEEP_W-1:0] shadow_data [DEPTH];
    int shadow_head  = 0;
    int shadow_tail  = 0;
    int shadow_count = 0;

    cmd_t cmd_backlog[$];
    rsp_t pending_replies[$];
    logic took_word = 1'b0;
    logic steady = 1'b0;
    int   mismatches = 0;
    int   words_taken = 0;
    int   full_drops = 0;
    int   empty_reads = 0;
    int   search_hits = 0;
    int   search_misses = 0;
    int   peak_fill = 0;
    int   quiet_cycles = 0;

    function automatic rsp_t predict_reply(cmd_t c);
        rsp_t r;
        r = '0;
        r.status = STATUS_OK;
        case (c.kind)
            KIND_PUSH:
            begin
                if (shadow_count == DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    shadow_ids[shadow_tail]  = c.passenger_id;
                    shadow_data[shadow_tail] = c.entry_data[KEEP_W-1:0];
                    shadow_tail = (shadow_tail + 1) % DEPTH;
                    shadow_count++;
                end
            end
            KIND_POP, KIND_PEEK:
            begin
                if (shadow_count == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    r.out_id   = shadow_ids[shadow_head];
                    r.out_data = FIELD_W'(shadow_data[shadow_head]);
                    if (c.kind == KIND_POP)
                    begin
                        shadow_head = (shadow_head + 1) % DEPTH;
                        shadow_count--;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_ids[(shadow_head + i) % DEPTH] == c.passenger_id)
                        r.found = 1'b1;
                end
            end
        endcase
        r.is_empty   = (shadow_count == 0);
        r.is_full    = (shadow_count == DEPTH);
        r.fill_count = COUNT_W'(shadow_count);
        return r;
    endfunction

    task automatic check_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    task automatic compare_reply(rsp_t want, rsp_t got);
        check_field("status", FIELD_W'(want.status), FIELD_W'(got.status));
        check_field("out_id", FIELD_W'(want.out_id), FIELD_W'(got.out_id));
        check_field("out_data", want.out_data, got.out_data);
        check_field("found", FIELD_W'(want.found), FIELD_W'(got.found));
        check_field("is_empty", FIELD_W'(want.is_empty), FIELD_W'(got.is_empty));
        check_field("is_full", FIELD_W'(want.is_full), FIELD_W'(got.is_full));
        check_field("fill_count", FIELD_W'(want.fill_count), FIELD_W'(got.fill_count));
    endtask

    // Monitor: retire results first, then log the word taken at this edge.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no word outstanding", $time);
            end
            else
            begin
                want = pending_replies.pop_front();
                compare_reply(want, result);
            end
        end
        if (rst_n && start && !busy)
        begin
            want = predict_reply(cmd);
            pending_replies.push_back(want);
            words_taken++;
            if (want.status == STATUS_FULL)
                full_drops++;
            if (want.status == STATUS_EMPTY)
                empty_reads++;
            if (cmd.kind == KIND_SEARCH && want.found)
                search_hits++;
            if (cmd.kind == KIND_SEARCH && !want.found)
                search_misses++;
            if (shadow_count > peak_fill)
                peak_fill = shadow_count;
        end
        took_word <= rst_n && start && !busy;
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("ring_fifo_with_id_search_unit regression: fail");
            $finish;
        end
    end

    // Driver: hold start until the word is taken, then advance or idle.
    always @(negedge clk)
    begin
        logic slot_open;
        slot_open = !start || took_word;
        if (slot_open)
        begin
            if (cmd_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 9))
            begin
                cmd <= cmd_backlog.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 99) < 75)
            return ID_W'($urandom_range(0, 7) * 16'h2491);
        return ID_W'($urandom);
    endfunction

    function automatic cmd_t make_word(kind_t k, logic [ID_W-1:0] id, logic [FIELD_W-1:0] d);
        cmd_t c;
        c.kind         = k;
        c.passenger_id = id;
        c.entry_data   = d;
        return c;
    endfunction

    task automatic queue_random(int count, int push_w, int pop_w);
        int roll;
        kind_t k;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < push_w)
                k = KIND_PUSH;
            else if (roll < push_w + pop_w)
                k = KIND_POP;
            else if (roll[0])
                k = KIND_PEEK;
            else
                k = KIND_SEARCH;
            cmd_backlog.push_back(make_word(k, pick_id(), FIELD_W'($urandom)));
        end
    endtask

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || start || pending_replies.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        cmd_backlog.push_back(make_word(KIND_POP, 16'h0000, 32'h0000_0000));
        cmd_backlog.push_back(make_word(KIND_PEEK, 16'hFFFF, 32'hFFFF_FFFF));
        cmd_backlog.push_back(make_word(KIND_SEARCH, 16'h0000, 32'h0000_0000));
        cmd_backlog.push_back(make_word(KIND_PUSH, 16'h0000, 32'h0000_0000));
        cmd_backlog.push_back(make_word(KIND_PUSH, 16'hFFFF, 32'hFFFF_FFFF));
        cmd_backlog.push_back(make_word(KIND_PUSH, 16'h5A5A, 32'hA5A5_A5A5));
        cmd_backlog.push_back(make_word(KIND_PEEK, 16'h0000, 32'h0000_0000));
        cmd_backlog.push_back(make_word(KIND_SEARCH, 16'hFFFF, 32'h0000_0000));
        cmd_backlog.push_back(make_word(KIND_SEARCH, 16'h0000, 32'hFFFF_FFFF));
        cmd_backlog.push_back(make_word(KIND_SEARCH, 16'h1234, 32'h0000_0000));
        cmd_backlog.push_back(make_word(KIND_SEARCH, 16'h5A5A, 32'h0000_0000));
        cmd_backlog.push_back(make_word(KIND_POP, 16'h0000, 32'h0000_0000));
        cmd_backlog.push_back(make_word(KIND_PEEK, 16'h0000, 32'h0000_0000));
        cmd_backlog.push_back(make_word(KIND_POP, 16'hFFFF, 32'hFFFF_FFFF));
        cmd_backlog.push_back(make_word(KIND_POP, 16'h0000, 32'h0000_0000));
        cmd_backlog.push_back(make_word(KIND_POP, 16'h0000, 32'h0000_0000));
        cmd_backlog.push_back(make_word(KIND_PEEK, 16'h0000, 32'h0000_0000));
        cmd_backlog.push_back(make_word(KIND_SEARCH, 16'h5A5A, 32'h0000_0000));
        wait_idle();

        steady = 1'b1;
        queue_random(100, 85, 5);
        wait_idle();
        steady = 1'b0;

        queue_random(100, 10, 75);
        queue_random(150, 45, 30);
        wait_idle();
        queue_random(100, 80, 10);
        queue_random(100, 5, 85);
        queue_random(100, 40, 30);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            mismatches += pending_replies.size();
            $display("%0d results never arrived", pending_replies.size());
        end

        $display("%0d words: %0d full drops, %0d empty reads, peak fill %0d of %0d",
                 words_taken, full_drops, empty_reads, peak_fill, DEPTH);
        $display("searches: %0d hits, %0d misses; %0d mismatches",
                 search_hits, search_misses, mismatches);
        if (mismatches == 0)
            $display("ring_fifo_with_id_search_unit regression: pass");
        else
            $display("ring_fifo_with_id_search_unit regression: fail");
        $finish;
    end

endmodule
